FILE: rtl/lcdbg_pkg.sv
package lcdbg_pkg;

    // screen and memory geometry
    localparam int unsigned SCREEN_W     = 160;
    localparam int unsigned PIX_PER_GRP  = 8;
    localparam int unsigned NUM_GROUPS   = (SCREEN_W + PIX_PER_GRP - 1) / PIX_PER_GRP;
    localparam int unsigned SHADE_W      = 2 * PIX_PER_GRP;
    localparam int unsigned PIX_W        = (PIX_PER_GRP > 1) ? $clog2(PIX_PER_GRP) : 1;
    localparam int unsigned GRP_W        = 5;
    localparam int unsigned VRAM_DEPTH   = 8192;
    localparam int unsigned VRAM_AW      = 13;
    localparam int unsigned OAM_DEPTH    = 160;
    localparam int unsigned OAM_AW       = 8;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // display modes
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    // mode lengths and line limits
    localparam logic [15:0] HBLANK_CYC = 16'd204;
    localparam logic [15:0] VBLANK_CYC = 16'd456;
    localparam logic [15:0] OAM_CYC    = 16'd80;
    localparam logic [15:0] XFER_CYC   = 16'd172;
    localparam logic [7:0]  VBLANK_ROW = 8'd144;
    localparam logic [7:0]  LAST_ROW   = 8'd153;

    // register addresses
    localparam logic [15:0] ADDR_LCDC = 16'hFF40;
    localparam logic [15:0] ADDR_STAT = 16'hFF41;
    localparam logic [15:0] ADDR_SCY  = 16'hFF42;
    localparam logic [15:0] ADDR_SCX  = 16'hFF43;
    localparam logic [15:0] ADDR_LY   = 16'hFF44;
    localparam logic [15:0] ADDR_LYC  = 16'hFF45;
    localparam logic [15:0] ADDR_WY   = 16'hFF4A;
    localparam logic [15:0] ADDR_WX   = 16'hFF4B;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_RESP,
        ST_MAP,
        ST_LO,
        ST_HI,
        ST_PIX,
        ST_GRP_OUT
    } state_t;

endpackage

FILE: rtl/lcdbg_ram.sv
module lcdbg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lcd_mode_timer_and_bg_renderer.sv
// LCD mode timer and background line renderer.
// Input channel s_*: one word per bus read, bus write or tick; s_tuser holds
// the operation. Output channel m_*: one word per result; m_tuser is the
// result kind and m_tlast marks the final word of an input.
// A read or write gives one word from the response state; a read of video
// RAM or the object table first passes a wait state. A tick gives one closing
// word, except at the end of pixel transfer with the LCD on: then it first
// gives 20 pixel groups, each group built from 8 pixels, each pixel through
// the map, low, high and pixel states (three reads of the single video RAM
// read port plus shade assembly). s_tready is high only while the block is
// idle; one input is in flight at a time.
// After reset the block sweeps video RAM and the object table to zero, one
// entry per cycle, over all 8192 video RAM entries with s_tready low.
// Registers reset to zero and the mode to pixel transfer.
// When the receiver holds m_tready low, the output word holds and the
// sequencer waits; no result is dropped.
module lcd_mode_timer_and_bg_renderer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address[15:0], write_data[23:16], cycles[29:24]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_data[7:0], vblank_irq[8], line_number[16:9],
                                   // group_index[21:17], pixel_shades[37:22]
    output logic        m_tuser,   // result_kind
    output logic        m_tlast    // last
);
    import lcdbg_pkg::*;

    state_t state_reg, state_next;

    logic [7:0]  lcdc_reg, lcdc_next;
    logic [7:0]  scy_reg, scy_next;
    logic [7:0]  scx_reg, scx_next;
    logic [7:0]  lyc_reg, lyc_next;
    logic [7:0]  wy_reg, wy_next;
    logic [7:0]  wx_reg, wx_next;
    logic [7:0]  row_reg, row_next;
    logic [1:0]  mode_reg, mode_next;
    logic [15:0] cnt_reg, cnt_next;

    logic [VRAM_AW-1:0] clr_reg, clr_next;
    logic [7:0]  resp_reg, resp_next;
    logic        irq_reg, irq_next;
    logic        sel_oam_reg, sel_oam_next;
    logic [7:0]  col_reg, col_next;
    logic [PIX_W-1:0] pix_reg, pix_next;
    logic [GRP_W-1:0] grp_reg, grp_next;
    logic [SHADE_W-1:0] sh_reg, sh_next;
    logic [VRAM_AW-1:0] taddr_reg, taddr_next;
    logic [7:0]  lo_reg, lo_next;

    logic        ov_reg, ov_next;
    logic        okind_reg, okind_next;
    logic [7:0]  ord_reg, ord_next;
    logic        oirq_reg, oirq_next;
    logic [7:0]  oline_reg, oline_next;
    logic [GRP_W-1:0] ogrp_reg, ogrp_next;
    logic [15:0] osh_reg, osh_next;
    logic        olast_reg, olast_next;

    logic               vram_we, oam_we;
    logic [VRAM_AW-1:0] vram_waddr, vram_raddr;
    logic [OAM_AW-1:0]  oam_waddr, oam_raddr;
    logic [7:0]         vram_wdata, oam_wdata, vram_rdata, oam_rdata;

    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [5:0]  cyc;
    logic        acc, out_free, in_vram, in_oam;
    logic [15:0] sum;
    logic [7:0]  row_inc;
    logic [7:0]  by, bx;
    logic [2:0]  bit_sel;
    logic [7:0]  tile_x;
    logic [VRAM_AW-1:0] tile_addr;
    logic [1:0]  shade;

    lcdbg_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH)) u_vram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    lcdbg_ram #(.WIDTH(8), .DEPTH(OAM_DEPTH)) u_oam (
        .clk   (clk),
        .we    (oam_we),
        .waddr (oam_waddr),
        .wdata (oam_wdata),
        .raddr (oam_raddr),
        .rdata (oam_rdata)
    );

    // unpack input word
    assign addr  = s_tdata[15:0];
    assign wdata = s_tdata[23:16];
    assign cyc   = s_tdata[29:24];

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign out_free = !ov_reg || m_tready;
    assign in_vram  = (addr >= 16'h8000) && (addr < 16'hA000);
    assign in_oam   = (addr >= 16'hFE00) && (addr < 16'hFEA0);

    // timer arithmetic
    assign sum     = cnt_reg + {10'd0, cyc};
    assign row_inc = row_reg + 8'd1;

    // background fetch address math
    assign by        = scy_reg + row_reg;
    assign bx        = col_reg + scx_reg;
    assign bit_sel   = 3'd7 - bx[2:0];
    assign tile_x    = vram_rdata ^ 8'h80;
    assign tile_addr = lcdc_reg[4] ? {1'b0, vram_rdata, by[2:0], 1'b0}
                                   : 13'h0800 + {1'b0, tile_x, by[2:0], 1'b0};
    assign shade     = (col_reg < 8'(SCREEN_W) && lcdc_reg[0])
                     ? {vram_rdata[bit_sel], lo_reg[bit_sel]} : 2'd0;

    // memory ports
    always_comb
    begin
        vram_we    = 1'b0;
        vram_waddr = addr[VRAM_AW-1:0];
        vram_wdata = wdata;
        oam_we     = 1'b0;
        oam_waddr  = OAM_AW'(addr - 16'hFE00);
        oam_wdata  = wdata;
        oam_raddr  = OAM_AW'(addr - 16'hFE00);
        vram_raddr = addr[VRAM_AW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                vram_we    = 1'b1;
                vram_waddr = clr_reg;
                vram_wdata = 8'd0;
                oam_we     = (clr_reg < VRAM_AW'(OAM_DEPTH));
                oam_waddr  = clr_reg[OAM_AW-1:0];
                oam_wdata  = 8'd0;
            end
            ST_IDLE:
            begin
                vram_we = acc && (s_tuser == OP_WRITE) && in_vram;
                oam_we  = acc && (s_tuser == OP_WRITE) && in_oam;
            end
            ST_MAP:  vram_raddr = {2'b11, lcdc_reg[3], by[7:3], bx[7:3]};
            ST_LO:   vram_raddr = tile_addr;
            ST_HI:   vram_raddr = {taddr_reg[VRAM_AW-1:1], 1'b1};
            default: vram_raddr = addr[VRAM_AW-1:0];
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        lcdc_next    = lcdc_reg;
        scy_next     = scy_reg;
        scx_next     = scx_reg;
        lyc_next     = lyc_reg;
        wy_next      = wy_reg;
        wx_next      = wx_reg;
        row_next     = row_reg;
        mode_next    = mode_reg;
        cnt_next     = cnt_reg;
        clr_next     = clr_reg;
        resp_next    = resp_reg;
        irq_next     = irq_reg;
        sel_oam_next = sel_oam_reg;
        col_next     = col_reg;
        pix_next     = pix_reg;
        grp_next     = grp_reg;
        sh_next      = sh_reg;
        taddr_next   = taddr_reg;
        lo_next      = lo_reg;
        ov_next      = ov_reg && !m_tready;
        okind_next   = okind_reg;
        ord_next     = ord_reg;
        oirq_next    = oirq_reg;
        oline_next   = oline_reg;
        ogrp_next    = ogrp_reg;
        osh_next     = osh_reg;
        olast_next   = olast_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == VRAM_AW'(VRAM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    resp_next  = 8'd0;
                    irq_next   = 1'b0;
                    state_next = ST_RESP;
                    case (s_tuser)
                        OP_READ:
                        begin
                            if (in_vram || in_oam)
                            begin
                                sel_oam_next = in_oam;
                                state_next   = ST_RD_WAIT;
                            end
                            else
                            begin
                                case (addr)
                                    ADDR_LCDC: resp_next = lcdc_reg;
                                    ADDR_STAT: resp_next = {5'd0, row_reg == lyc_reg, mode_reg};
                                    ADDR_SCY:  resp_next = scy_reg;
                                    ADDR_SCX:  resp_next = scx_reg;
                                    ADDR_LY:   resp_next = row_reg;
                                    ADDR_LYC:  resp_next = lyc_reg;
                                    ADDR_WY:   resp_next = wy_reg;
                                    ADDR_WX:   resp_next = wx_reg;
                                    default:   resp_next = 8'd0;
                                endcase
                            end
                        end
                        OP_WRITE:
                        begin
                            case (addr)
                                ADDR_LCDC: lcdc_next = wdata;
                                ADDR_SCY:  scy_next  = wdata;
                                ADDR_SCX:  scx_next  = wdata;
                                ADDR_LY:   row_next  = 8'd0;
                                ADDR_LYC:  lyc_next  = wdata;
                                ADDR_WY:   wy_next   = wdata;
                                ADDR_WX:   wx_next   = wdata;
                                default:   lcdc_next = lcdc_reg;
                            endcase
                        end
                        OP_TICK:
                        begin
                            cnt_next = sum;
                            case (mode_reg)
                                MODE_HBLANK:
                                begin
                                    if (sum >= HBLANK_CYC)
                                    begin
                                        cnt_next = 16'd0;
                                        row_next = row_inc;
                                        if (row_inc == VBLANK_ROW)
                                        begin
                                            mode_next = MODE_VBLANK;
                                            irq_next  = 1'b1;
                                        end
                                        else
                                        begin
                                            mode_next = MODE_OAM;
                                        end
                                    end
                                end
                                MODE_VBLANK:
                                begin
                                    if (sum >= VBLANK_CYC)
                                    begin
                                        cnt_next = 16'd0;
                                        row_next = row_inc;
                                        if (row_inc > LAST_ROW)
                                        begin
                                            mode_next = MODE_OAM;
                                            row_next  = 8'd0;
                                        end
                                    end
                                end
                                MODE_OAM:
                                begin
                                    if (sum >= OAM_CYC)
                                    begin
                                        cnt_next  = 16'd0;
                                        mode_next = MODE_XFER;
                                    end
                                end
                                default:
                                begin
                                    if (sum >= XFER_CYC)
                                    begin
                                        cnt_next  = 16'd0;
                                        mode_next = MODE_HBLANK;
                                        if (lcdc_reg[7])
                                        begin
                                            col_next   = 8'd0;
                                            pix_next   = '0;
                                            grp_next   = '0;
                                            sh_next    = '0;
                                            state_next = ST_MAP;
                                        end
                                        else
                                        begin
                                            row_next  = 8'd0;
                                            mode_next = MODE_VBLANK;
                                        end
                                    end
                                end
                            endcase
                        end
                        default: resp_next = 8'd0;
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                resp_next  = sel_oam_reg ? oam_rdata : vram_rdata;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // emit the closing word
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = 1'b0;
                    ord_next   = resp_reg;
                    oirq_next  = irq_reg;
                    oline_next = 8'd0;
                    ogrp_next  = '0;
                    osh_next   = 16'd0;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MAP:  state_next = ST_LO;
            ST_LO:
            begin
                taddr_next = tile_addr;
                state_next = ST_HI;
            end
            ST_HI:
            begin
                lo_next    = vram_rdata;
                state_next = ST_PIX;
            end
            ST_PIX:
            begin
                // shift in one pixel and advance
                sh_next  = {sh_reg[SHADE_W-3:0], shade};
                col_next = col_reg + 8'd1;
                pix_next = pix_reg + 1'b1;
                if (pix_reg == PIX_W'(PIX_PER_GRP - 1))
                begin
                    pix_next   = '0;
                    state_next = ST_GRP_OUT;
                end
                else
                begin
                    state_next = ST_MAP;
                end
            end
            ST_GRP_OUT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = 1'b1;
                    ord_next   = 8'd0;
                    oirq_next  = 1'b0;
                    oline_next = row_reg;
                    ogrp_next  = grp_reg;
                    osh_next   = 16'(sh_reg);
                    olast_next = 1'b0;
                    sh_next    = '0;
                    grp_next   = grp_reg + 1'b1;
                    if (grp_reg == GRP_W'(NUM_GROUPS - 1))
                    begin
                        resp_next  = 8'd0;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_MAP;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and register state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            lcdc_reg  <= 8'd0;
            scy_reg   <= 8'd0;
            scx_reg   <= 8'd0;
            lyc_reg   <= 8'd0;
            wy_reg    <= 8'd0;
            wx_reg    <= 8'd0;
            row_reg   <= 8'd0;
            mode_reg  <= MODE_XFER;
            cnt_reg   <= 16'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            lcdc_reg  <= lcdc_next;
            scy_reg   <= scy_next;
            scx_reg   <= scx_next;
            lyc_reg   <= lyc_next;
            wy_reg    <= wy_next;
            wx_reg    <= wx_next;
            row_reg   <= row_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        resp_reg    <= resp_next;
        irq_reg     <= irq_next;
        sel_oam_reg <= sel_oam_next;
        col_reg     <= col_next;
        pix_reg     <= pix_next;
        grp_reg     <= grp_next;
        sh_reg      <= sh_next;
        taddr_reg   <= taddr_next;
        lo_reg      <= lo_next;
        okind_reg   <= okind_next;
        ord_reg     <= ord_next;
        oirq_reg    <= oirq_next;
        oline_reg   <= oline_next;
        ogrp_reg    <= ogrp_next;
        osh_reg     <= osh_next;
        olast_reg   <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {2'b00, osh_reg, ogrp_reg, oline_reg, oirq_reg, ord_reg};

endmodule
